[src/hgt_pkg.sv]
// ----------------------------------------------------------------------------
// Height map grid triangulator package
// Shared widths, configuration register indexes and the sample descriptor
// that travels from the raster counter to the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package hgt_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int GRID_W    = 11;
    localparam int SPACING_W = 24;
    localparam int HEIGHT_W  = 32;
    localparam int POS_W     = 34;
    localparam int IDX_W     = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int CSIZE_W = (GRID_W > COLS_W) ? GRID_W : COLS_W;
    localparam int RSIZE_W = (GRID_W > ROWS_W) ? GRID_W : ROWS_W;
    localparam int XPROD_W = (COL_W + SPACING_W > POS_W) ? COL_W + SPACING_W : POS_W;
    localparam int YPROD_W = (ROW_W + SPACING_W > POS_W) ? ROW_W + SPACING_W : POS_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 160;

    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLUMNS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_SPACING = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_SPACING    = 2'd3;

    localparam logic [GRID_W-1:0]    RST_GRID_COLUMNS   = 11'd1024;
    localparam logic [GRID_W-1:0]    RST_GRID_ROWS      = 11'd1024;
    localparam logic [SPACING_W-1:0] RST_COLUMN_SPACING = 24'd6406;
    localparam logic [SPACING_W-1:0] RST_ROW_SPACING    = 24'd12812;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [IDX_W-1:0] idx_tl;
        logic [IDX_W-1:0] idx_tr;
        logic [IDX_W-1:0] idx_bl;
        logic [IDX_W-1:0] idx_br;
        logic             on_edge;
    } t_sample;

endpackage

`default_nettype wire

[src/hgt_raster.sv]
// ----------------------------------------------------------------------------
// Raster position generator
// Holds the grid registers and the column, row and vertex index counters,
// and describes the sample at the current raster position.
// ----------------------------------------------------------------------------
`default_nettype none

module hgt_raster (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [hgt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire  [hgt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire                               i_advance,
    output hgt_pkg::t_sample                  o_sample
);
    import hgt_pkg::*;

    logic [GRID_W-1:0]    r_grid_columns;
    logic [GRID_W-1:0]    r_grid_rows;
    logic [SPACING_W-1:0] r_column_spacing;
    logic [SPACING_W-1:0] r_row_spacing;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_vidx, n_vidx;

    logic [CSIZE_W-1:0] cols_ext;
    logic [CSIZE_W-1:0] cols_clamped;
    logic [RSIZE_W-1:0] rows_ext;
    logic [RSIZE_W-1:0] rows_clamped;
    logic [COL_W-1:0]   col_last_pos;
    logic [ROW_W-1:0]   row_last_pos;
    logic               is_last_col;
    logic               is_last_row;
    logic [XPROD_W-1:0] x_prod;
    logic [YPROD_W-1:0] y_prod;
    logic               restart;

    always_comb begin
        cols_ext = CSIZE_W'(r_grid_columns);
        rows_ext = RSIZE_W'(r_grid_rows);
        if (cols_ext < CSIZE_W'(2)) begin
            cols_clamped = CSIZE_W'(2);
        end else if (cols_ext > CSIZE_W'(MAX_COLUMNS)) begin
            cols_clamped = CSIZE_W'(MAX_COLUMNS);
        end else begin
            cols_clamped = cols_ext;
        end
        if (rows_ext < RSIZE_W'(2)) begin
            rows_clamped = RSIZE_W'(2);
        end else if (rows_ext > RSIZE_W'(MAX_ROWS)) begin
            rows_clamped = RSIZE_W'(MAX_ROWS);
        end else begin
            rows_clamped = rows_ext;
        end
        col_last_pos = COL_W'(cols_clamped - CSIZE_W'(1));
        row_last_pos = ROW_W'(rows_clamped - RSIZE_W'(1));
        is_last_col  = (r_col >= col_last_pos);
        is_last_row  = (r_row >= row_last_pos);

        x_prod = XPROD_W'(r_col) * XPROD_W'(r_column_spacing);
        y_prod = YPROD_W'(r_row) * YPROD_W'(r_row_spacing);

        o_sample.pos_x   = (x_prod > XPROD_W'({POS_W{1'b1}})) ? {POS_W{1'b1}}
                                                               : x_prod[POS_W-1:0];
        o_sample.pos_y   = (y_prod > YPROD_W'({POS_W{1'b1}})) ? {POS_W{1'b1}}
                                                               : y_prod[POS_W-1:0];
        o_sample.idx_tl  = r_vidx;
        o_sample.idx_tr  = r_vidx + IDX_W'(1);
        o_sample.idx_bl  = r_vidx + IDX_W'(cols_clamped);
        o_sample.idx_br  = r_vidx + IDX_W'(cols_clamped) + IDX_W'(1);
        o_sample.on_edge = is_last_col || is_last_row;
    end

    assign restart = i_cfg_we &&
                     ((i_cfg_addr == CFG_GRID_COLUMNS) || (i_cfg_addr == CFG_GRID_ROWS));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_vidx = r_vidx;
        if (restart) begin
            n_col  = '0;
            n_row  = '0;
            n_vidx = '0;
        end else if (i_advance) begin
            if (is_last_col) begin
                n_col = '0;
                if (is_last_row) begin
                    n_row  = '0;
                    n_vidx = '0;
                end else begin
                    n_row  = r_row + ROW_W'(1);
                    n_vidx = r_vidx + IDX_W'(1);
                end
            end else begin
                n_col  = r_col + COL_W'(1);
                n_vidx = r_vidx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col            <= '0;
            r_row            <= '0;
            r_vidx           <= '0;
            r_grid_columns   <= RST_GRID_COLUMNS;
            r_grid_rows      <= RST_GRID_ROWS;
            r_column_spacing <= RST_COLUMN_SPACING;
            r_row_spacing    <= RST_ROW_SPACING;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_vidx <= n_vidx;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_GRID_COLUMNS:   r_grid_columns   <= i_cfg_wdata[GRID_W-1:0];
                    CFG_GRID_ROWS:      r_grid_rows      <= i_cfg_wdata[GRID_W-1:0];
                    CFG_COLUMN_SPACING: r_column_spacing <= i_cfg_wdata[SPACING_W-1:0];
                    CFG_ROW_SPACING:    r_row_spacing    <= i_cfg_wdata[SPACING_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    a_origin_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == '0 && r_row == '0) |-> (r_vidx == '0))
        else $error("vertex index is not zero at the grid origin");

endmodule

`default_nettype wire

[src/heightmap_grid_triangulator_top.sv]
// ----------------------------------------------------------------------------
// Height map grid triangulator
// Turns raster-ordered height samples into a vertex result and, away from the
// last row and column, two triangle results that index the grid's vertices.
// Each sample is registered on transfer; its results then go one by one
// through the single result register, which takes one result per cycle while
// the output is not stalled, and the next sample is taken with its last one.
// Reset clears the counters, the grid registers to their defaults and all
// valid flags; a grid size write restarts the raster at the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_grid_triangulator_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [hgt_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire  [hgt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [hgt_pkg::S_TDATA_W-1:0]      s_tdata,   // height
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [hgt_pkg::M_TDATA_W-1:0]      m_tdata,   // pos_x, pos_y, pos_z, a, b, c
    output logic                               m_tuser,   // kind
    output logic                               m_tlast
);
    import hgt_pkg::*;

    typedef enum logic [2:0] {
        PH_VERTEX = 3'b001,
        PH_TRI_A  = 3'b010,
        PH_TRI_B  = 3'b100
    } t_phase;

    typedef struct packed {
        logic                kind;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [HEIGHT_W-1:0] pos_z;
        logic [IDX_W-1:0]    corner_a;
        logic [IDX_W-1:0]    corner_b;
        logic [IDX_W-1:0]    corner_c;
        logic                last;
    } t_result;

    t_sample             sample;
    t_sample             r_smp;
    logic [HEIGHT_W-1:0] r_height;
    logic                r_item_vld;
    t_phase              r_phase, n_phase;
    t_result             r_out, n_out;
    logic                r_out_vld;
    logic                out_free;
    logic                emit;
    logic                item_done;
    logic                s_accept;

    hgt_raster u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (s_accept),
        .o_sample    (sample)
    );

    assign out_free  = !r_out_vld || m_tready;
    assign emit      = r_item_vld && out_free;
    assign item_done = emit && ((r_phase == PH_TRI_B) ||
                                ((r_phase == PH_VERTEX) && r_smp.on_edge));
    assign s_tready  = !r_item_vld || item_done;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        n_out   = '0;
        n_phase = r_phase;
        unique case (r_phase)
            PH_VERTEX: begin
                n_out.kind  = KIND_VERTEX;
                n_out.pos_x = r_smp.pos_x;
                n_out.pos_y = r_smp.pos_y;
                n_out.pos_z = r_height;
                n_out.last  = r_smp.on_edge;
                n_phase     = PH_TRI_A;
            end
            PH_TRI_A: begin
                n_out.kind     = KIND_TRIANGLE;
                n_out.corner_a = r_smp.idx_tl;
                n_out.corner_b = r_smp.idx_tr;
                n_out.corner_c = r_smp.idx_bl;
                n_phase        = PH_TRI_B;
            end
            PH_TRI_B: begin
                n_out.kind     = KIND_TRIANGLE;
                n_out.corner_a = r_smp.idx_tr;
                n_out.corner_b = r_smp.idx_br;
                n_out.corner_c = r_smp.idx_bl;
                n_out.last     = 1'b1;
                n_phase        = PH_VERTEX;
            end
            default: begin
                n_phase = PH_VERTEX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_phase    <= PH_VERTEX;
            r_out_vld  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_item_vld <= 1'b1;
                r_phase    <= PH_VERTEX;
            end else if (item_done) begin
                r_item_vld <= 1'b0;
                r_phase    <= PH_VERTEX;
            end else if (emit) begin
                r_phase <= n_phase;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_smp    <= sample;
            r_height <= s_tdata[HEIGHT_W-1:0];
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out.kind;
    assign m_tlast  = r_out.last;
    assign m_tdata  = {r_out.corner_c, r_out.corner_b, r_out.corner_a,
                       r_out.pos_z, r_out.pos_y, r_out.pos_x};

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_vld && !item_done) |=> r_item_vld)
        else $error("sample dropped before all its results were sent");

    a_edge_no_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_vld && r_phase != PH_VERTEX) |-> !r_smp.on_edge)
        else $error("triangle phase reached for an edge sample");

    a_tri_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == KIND_TRIANGLE) |->
        (r_out.pos_x == '0 && r_out.pos_y == '0 && r_out.pos_z == '0))
        else $error("triangle result carries coordinates");

    a_vertex_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == KIND_VERTEX) |->
        (r_out.corner_a == '0 && r_out.corner_b == '0 && r_out.corner_c == '0))
        else $error("vertex result carries corner indexes");

endmodule

`default_nettype wire
